// File: hw/rtl/arh_pkg.sv
// ----------------------------------------------------------------------------
// Allele ratio histogram package
// Shared constants, types and helper functions for the histogram block.
// ----------------------------------------------------------------------------
`default_nettype none

package arh_pkg;

    // Sizing of the block.
    localparam int LANES       = 9;
    localparam int MAX_BINS    = 128;
    localparam int COUNT_WIDTH = 16;

    localparam int PCT_FULL    = 100;

    localparam int LANE_W      = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int BIN_W       = $clog2(MAX_BINS);
    localparam int MEM_DEPTH   = LANES * MAX_BINS;
    localparam int ADDR_W      = $clog2(MEM_DEPTH);

    // Bins per range never exceeds 100, so the quotient fits in seven bits.
    localparam int BPR_W       = 7;
    localparam int SUM_W       = COUNT_WIDTH + 1;
    localparam int DIV_W       = COUNT_WIDTH + BPR_W;
    localparam int STEP_W      = $clog2(BPR_W);

    // Width used for comparing bin numbers, read bins and bin counts in use.
    localparam int CMP_W       = 9;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_ADDR_W  = 3;

    localparam logic [31:0] CNT_SAT = 32'hFFFF_FFFF;

    typedef enum logic [0:0] {
        CMD_ACCUM = 1'b0,
        CMD_READ  = 1'b1
    } cmd_t;

    typedef enum logic [0:0] {
        REG_MIN_READ = 1'b0,
        REG_BIN_SIZE = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_UPDATE,
        ST_EMIT
    } bk_state_t;

    // One classified item as it travels from the front end to the back end.
    typedef struct packed {
        logic                   is_read;
        logic                   lane_ok;
        logic                   counted;
        logic                   rbin_ok;
        logic [LANE_W-1:0]      lane;
        logic [COUNT_WIDTH-1:0] ref_cnt;
        logic [SUM_W-1:0]       sum;
        logic [BPR_W-1:0]       bpr;
        logic [6:0]             rbin;
    } op_t;

    typedef struct packed {
        logic        accepted;
        logic [6:0]  bin_out;
        logic [31:0] bin_value;
        logic [31:0] lane_total;
        logic        index_error;
    } res_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } q_status_t;

    // Bins per range (100 div bin_size) for every 7-bit bin size; zero acts as one.
    typedef logic [BPR_W-1:0] bpr_table_t [0:127];

    // The table is worked out by repeated subtraction when the design is built.
    function automatic bpr_table_t build_bpr_table();
        bpr_table_t tbl;
        int         quo;
        int         left;
        int         step;
        for (int i = 0; i < 128; i++)
        begin
            step = (i == 0) ? 1 : i;
            quo  = 0;
            left = PCT_FULL;
            while (left >= step)
            begin
                left = left - step;
                quo  = quo + 1;
            end
            tbl[i] = BPR_W'(quo);
        end
        return tbl;
    endfunction

    localparam bpr_table_t BPR_TABLE = build_bpr_table();

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == CNT_SAT) ? v : v + 32'd1;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/arh_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module arh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: hw/rtl/arh_front.sv
// ----------------------------------------------------------------------------
// Histogram front end
// Accepts item beats and classifies them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module arh_front (
    input  wire logic                 item_valid,
    output logic                      item_stall,
    input  wire logic                 command,
    input  wire logic [3:0]           lane,
    input  wire logic [15:0]          ref_count,
    input  wire logic [15:0]          alt_count,
    input  wire logic [6:0]           read_bin,
    input  wire logic [15:0]          min_read_count,
    input  wire logic [6:0]           bin_size,
    input  wire logic                 clearing,
    input  wire arh_pkg::q_status_t   qstat,
    output logic                      push,
    output arh_pkg::op_t              op
);
    import arh_pkg::*;

    localparam int THR_W = (SUM_W > 16) ? SUM_W : 16;

    cmd_t                   cmd;
    logic                   lane_ok;
    logic [COUNT_WIDTH-1:0] ref_w;
    logic [COUNT_WIDTH-1:0] alt_w;
    logic [SUM_W-1:0]       sum;
    logic                   over_thr;
    logic [BPR_W-1:0]       bpr;
    logic [CMP_W-1:0]       bpr_p1;
    logic [CMP_W-1:0]       bins_in_use;

    always_comb
    begin
        cmd      = cmd_t'(command);
        lane_ok  = {1'b0, lane} < 5'(LANES);
        ref_w    = COUNT_WIDTH'(ref_count);
        alt_w    = COUNT_WIDTH'(alt_count);
        sum      = SUM_W'(ref_w) + SUM_W'(alt_w);
        over_thr = (sum != '0) && (THR_W'(sum) >= THR_W'(min_read_count));

        bpr         = BPR_TABLE[bin_size];
        bpr_p1      = CMP_W'(bpr) + CMP_W'(1);
        bins_in_use = (bpr_p1 > CMP_W'(MAX_BINS)) ? CMP_W'(MAX_BINS) : bpr_p1;

        op.is_read = (cmd == CMD_READ);
        op.lane_ok = lane_ok;
        op.counted = (cmd == CMD_ACCUM) && lane_ok && over_thr;
        op.rbin_ok = CMP_W'(read_bin) < bins_in_use;
        op.lane    = LANE_W'(lane);
        op.ref_cnt = ref_w;
        op.sum     = sum;
        op.bpr     = bpr;
        op.rbin    = read_bin;
    end

    assign item_stall = clearing | qstat.full;
    assign push       = item_valid & ~item_stall;

endmodule

`default_nettype wire

// File: hw/rtl/arh_queue.sv
// ----------------------------------------------------------------------------
// Histogram operation queue
// Short register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module arh_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire arh_pkg::op_t       op_in,
    input  wire logic               pop,
    output arh_pkg::op_t            head,
    output arh_pkg::q_status_t      qstat
);
    import arh_pkg::*;

    op_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= op_in;
        end
    end

    assign head        = mem_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign qstat.count = count_reg;

endmodule

`default_nettype wire

// File: hw/rtl/arh_back.sv
// ----------------------------------------------------------------------------
// Histogram back end
// Divides out the bin, updates the bin store and lane totals, drives results.
// ----------------------------------------------------------------------------
`default_nettype none

module arh_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire arh_pkg::op_t       head,
    input  wire arh_pkg::q_status_t qstat,
    output logic                    pop,
    output logic                    clearing,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output arh_pkg::res_t           result
);
    import arh_pkg::*;

    bk_state_t           state_reg;
    bk_state_t           state_next;
    op_t                 op_reg;
    logic [ADDR_W-1:0]   clr_cnt_reg;
    logic [DIV_W-1:0]    rem_reg;
    logic [DIV_W-1:0]    dsh_reg;
    logic [BPR_W-1:0]    quo_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [31:0]         lane_total_reg [LANES];
    res_t                res_reg;
    res_t                out_res_reg;
    logic                out_valid_reg;

    logic                out_free;
    logic                div_ge;
    logic [BIN_W-1:0]    bin_acc;
    logic [BIN_W-1:0]    bin_sel;
    logic [ADDR_W-1:0]   mem_addr;
    logic [31:0]         cur_total;
    logic [31:0]         new_count;
    logic [31:0]         new_total;
    res_t                res_idle;
    res_t                res_upd;

    logic                ram_wr_en;
    logic [ADDR_W-1:0]   ram_wr_addr;
    logic [31:0]         ram_wr_data;
    logic                ram_rd_en;
    logic [31:0]         ram_rd_data;
    logic                load_out;

    arh_ram #(
        .WIDTH (32),
        .DEPTH (MEM_DEPTH)
    ) u_bin_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (mem_addr),
        .rd_data (ram_rd_data)
    );

    // Datapath values derived from the operation in hand.
    always_comb
    begin
        out_free  = !out_valid_reg || !result_stall;
        div_ge    = rem_reg >= dsh_reg;
        bin_acc   = (CMP_W'(quo_reg) > CMP_W'(MAX_BINS - 1)) ? BIN_W'(MAX_BINS - 1)
                                                              : BIN_W'(quo_reg);
        bin_sel   = op_reg.is_read ? BIN_W'(op_reg.rbin) : bin_acc;
        mem_addr  = ADDR_W'(ADDR_W'(op_reg.lane) * ADDR_W'(MAX_BINS)) + ADDR_W'(bin_sel);
        cur_total = lane_total_reg[op_reg.lane];
        new_count = op_reg.is_read ? ram_rd_data : sat_inc(ram_rd_data);
        new_total = op_reg.is_read ? cur_total : sat_inc(cur_total);

        res_upd.accepted    = !op_reg.is_read;
        res_upd.bin_out     = 7'(bin_sel);
        res_upd.bin_value   = new_count;
        res_upd.lane_total  = new_total;
        res_upd.index_error = 1'b0;

        // Items that never touch the bin store: rejected samples, bad lanes, bad bins.
        res_idle.accepted    = 1'b0;
        res_idle.bin_out     = head.is_read ? head.rbin : 7'd0;
        res_idle.bin_value   = 32'd0;
        res_idle.lane_total  = head.lane_ok ? lane_total_reg[head.lane] : 32'd0;
        res_idle.index_error = head.is_read && !(head.lane_ok && head.rbin_ok);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == ADDR_W'(MEM_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!qstat.empty)
                begin
                    if (head.counted)
                    begin
                        state_next = ST_DIV;
                    end
                    else if (head.is_read && head.lane_ok && head.rbin_ok)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_DIV:
            begin
                if (step_reg == '0)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = out_free ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT:
            begin
                state_next = out_free ? ST_IDLE : ST_EMIT;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        pop         = 1'b0;
        clearing    = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = mem_addr;
        ram_wr_data = new_count;
        ram_rd_en   = 1'b0;
        load_out    = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                clearing    = 1'b1;
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_cnt_reg;
                ram_wr_data = 32'd0;
            end
            ST_IDLE:
            begin
                pop = !qstat.empty;
            end
            ST_READ:
            begin
                ram_rd_en = 1'b1;
            end
            ST_UPDATE:
            begin
                ram_wr_en = !op_reg.is_read;
                load_out  = out_free;
            end
            ST_EMIT:
            begin
                load_out = out_free;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < LANES; i++)
            begin
                lane_total_reg[i] <= 32'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (state_reg == ST_UPDATE && !op_reg.is_read)
            begin
                lane_total_reg[op_reg.lane] <= new_total;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            op_reg   <= head;
            rem_reg  <= DIV_W'(head.bpr * head.ref_cnt);
            dsh_reg  <= DIV_W'(head.sum) << (BPR_W - 1);
            quo_reg  <= '0;
            step_reg <= STEP_W'(BPR_W - 1);
            res_reg  <= res_idle;
        end
        else if (state_reg == ST_DIV)
        begin
            if (div_ge)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            quo_reg  <= {quo_reg[BPR_W-2:0], div_ge};
            dsh_reg  <= dsh_reg >> 1;
            step_reg <= step_reg - STEP_W'(1);
        end
        else if (state_reg == ST_UPDATE)
        begin
            res_reg <= res_upd;
        end
        if (load_out)
        begin
            out_res_reg <= (state_reg == ST_UPDATE) ? res_upd : res_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_res_reg;

endmodule

`default_nettype wire

// File: hw/rtl/allele_ratio_histogram_core.sv
// ----------------------------------------------------------------------------
// Allele ratio histogram core
// Per-lane histograms of reference-allele fraction with saturating counts.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                   Direction   Notes
//  item      item_valid/item_stall + fields            in          accumulate or read
//  result    result_valid/result_stall + fields        out         one beat per item
//  config    psel/penable/pwrite/paddr/pwdata/prdata   in/out      APB, pready tied high
//
// A beat is registered in the operation queue before the back end picks it up.
// In the back end a counted sample then steps through loading the beat and forming
// the product, the one-bit-a-step restoring divider, the bin store read and the
// write back. A valid read skips the divider; any other item goes straight to emit.
// After reset the bin store is cleared one entry a cycle while item_stall is
// held high; configuration writes are taken throughout.
// A stalled result sits in the output register while the next item is worked on;
// the back end only waits once it has a second result ready to hand over.
//
`default_nettype none

module allele_ratio_histogram_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [arh_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                      pwdata,
    output logic      [31:0]                      prdata,
    output logic                                  pready,

    input  wire logic                             item_valid,
    output logic                                  item_stall,
    input  wire logic                             command,
    input  wire logic [3:0]                       lane,
    input  wire logic [15:0]                      ref_count,
    input  wire logic [15:0]                      alt_count,
    input  wire logic [6:0]                       read_bin,

    output logic                                  result_valid,
    input  wire logic                             result_stall,
    output logic                                  accepted,
    output logic      [6:0]                       bin_out,
    output logic      [31:0]                      bin_value,
    output logic      [31:0]                      lane_total,
    output logic                                  index_error
);
    import arh_pkg::*;

    // Configuration registers. The low two address bits are ignored, so each
    // register occupies one 32-bit word.
    logic [15:0] min_read_count_reg;
    logic [6:0]  bin_size_reg;
    reg_idx_t    reg_idx;
    logic        cfg_write;

    // Front to back plumbing.
    logic        push;
    logic        pop;
    logic        clearing;
    op_t         op_front;
    op_t         op_head;
    q_status_t   qstat;
    res_t        result;

    assign reg_idx   = reg_idx_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_read_count_reg <= 16'd1;
            bin_size_reg       <= 7'd10;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_MIN_READ:
                begin
                    min_read_count_reg <= pwdata[15:0];
                end
                REG_BIN_SIZE:
                begin
                    bin_size_reg <= pwdata[6:0];
                end
                default:
                begin
                    min_read_count_reg <= min_read_count_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MIN_READ: prdata = {16'd0, min_read_count_reg};
            REG_BIN_SIZE: prdata = {25'd0, bin_size_reg};
            default:      prdata = 32'd0;
        endcase
    end

    // The front end classifies each beat: lane range, threshold, bins per
    // range from the bin size table, and whether a read bin is in use.
    arh_front u_front (
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .command        (command),
        .lane           (lane),
        .ref_count      (ref_count),
        .alt_count      (alt_count),
        .read_bin       (read_bin),
        .min_read_count (min_read_count_reg),
        .bin_size       (bin_size_reg),
        .clearing       (clearing),
        .qstat          (qstat),
        .push           (push),
        .op             (op_front)
    );

    arh_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .op_in (op_front),
        .pop   (pop),
        .head  (op_head),
        .qstat (qstat)
    );

    // The back end owns the bin store, the lane totals and the output register.
    arh_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (op_head),
        .qstat        (qstat),
        .pop          (pop),
        .clearing     (clearing),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    assign accepted    = result.accepted;
    assign bin_out     = result.bin_out;
    assign bin_value   = result.bin_value;
    assign lane_total  = result.lane_total;
    assign index_error = result.index_error;

    // No item may enter while the bin store is being cleared.
    a_no_item_during_clear: assert property (
        @(posedge clk) disable iff (!rst_n)
        clearing |-> item_stall
    ) else $error("item channel open during bin store clear");

    // The queue never holds more than its depth.
    a_queue_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        qstat.count <= QCNT_W'(QUEUE_DEPTH)
    ) else $error("operation queue overfilled");

    // A counted sample leaves a non-zero bin and lane total and no error.
    a_counted_consistent: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_valid && accepted) |-> (!index_error && bin_value != 32'd0
                                        && lane_total != 32'd0)
    ) else $error("counted sample with inconsistent result");

    // An erroneous read never reports a bin count.
    a_error_no_value: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_valid && index_error) |-> (bin_value == 32'd0 && !accepted)
    ) else $error("index error with a bin value");

endmodule

`default_nettype wire

// File: tb/sv/tb_allele_ratio_histogram_core.sv
// ----------------------------------------------------------------------------
// Allele ratio histogram core testbench
// Drives accumulate and read beats into the core under several register
// settings, predicts every result beat from a private copy of the histogram
// and lane totals, and compares the two field by field. Both channels idle at
// random, and one long receiver hold-off backs the core up into its input.
// ----------------------------------------------------------------------------

module tb_allele_ratio_histogram_core;

    import arh_pkg::*;

    // Random beats per register setting; six settings give about 2000 in all.
    localparam int PHASE_BEATS     = 330;
    // Cycles allowed after the last result before a register write or the
    // end of the run.
    localparam int DRAIN_CYCLES    = 16;
    // Length of the deliberate receiver hold-off.
    localparam int HOLD_OFF_CYCLES = 300;
    // Cycles without any beat moving before the run is declared hung. The
    // longest honest quiet spell is the clearing pass after reset.
    localparam int QUIET_LIMIT     = 4000;
    localparam int PRINT_CAP       = 40;

    typedef struct {
        cmd_t        cmd;
        logic [3:0]  lane;
        logic [15:0] ref_reads;
        logic [15:0] alt_reads;
        logic [6:0]  bin_sel;
    } sample_t;

    // ------------------------------------------------------------------------
    // Clock, reset and the block's inputs, all known from time zero.
    // ------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [31:0]           pwdata  = '0;
    logic [31:0]           prdata;
    logic                  pready;

    logic        item_valid = 1'b0;
    logic        item_stall;
    logic        command    = 1'b0;
    logic [3:0]  lane       = '0;
    logic [15:0] ref_count  = '0;
    logic [15:0] alt_count  = '0;
    logic [6:0]  read_bin   = '0;

    logic        result_valid;
    logic        result_stall = 1'b0;
    logic        accepted;
    logic [6:0]  bin_out;
    logic [31:0] bin_value;
    logic [31:0] lane_total;
    logic        index_error;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    allele_ratio_histogram_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .command      (command),
        .lane         (lane),
        .ref_count    (ref_count),
        .alt_count    (alt_count),
        .read_bin     (read_bin),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .accepted     (accepted),
        .bin_out      (bin_out),
        .bin_value    (bin_value),
        .lane_total   (lane_total),
        .index_error  (index_error)
    );

    // ------------------------------------------------------------------------
    // Shared testbench state.
    // ------------------------------------------------------------------------
    sample_t     pending_samples[$];   // beats waiting to be offered
    res_t        expected_results[$];  // predictions waiting for their result beat
    int unsigned mismatch_count = 0;
    int unsigned result_number  = 0;
    bit          idling_on      = 1'b1;
    int unsigned holds_asked    = 0;   // long hold-offs requested by the stimulus
    int unsigned holds_served   = 0;   // long hold-offs started by the monitor

    // Our own copy of what the core holds: the histograms, the lane totals
    // and the two registers as last written.
    logic [31:0] bin_tally  [0:MEM_DEPTH-1];
    logic [31:0] lane_tally [0:LANES-1];
    logic [15:0] cfg_min_reads = 16'd1;
    logic [6:0]  cfg_bin_size  = 7'd10;

    // ------------------------------------------------------------------------
    // Prediction.
    // ------------------------------------------------------------------------

    // Number of bins one hundred percent is split into; a bin size of zero
    // behaves as one, and a size above one hundred leaves a single bin.
    function automatic int unsigned pct_bins();
        return (cfg_bin_size == 7'd0) ? PCT_FULL : PCT_FULL / int'(cfg_bin_size);
    endfunction

    function automatic int unsigned bins_used();
        int unsigned n;
        n = pct_bins() + 1;
        return (n > MAX_BINS) ? MAX_BINS : n;
    endfunction

    // Applies one beat to the private histogram and returns the result beat
    // the core ought to produce for it.
    function automatic res_t tally_sample(input sample_t s);
        res_t                r;
        longint unsigned     cnt_mask;
        longint unsigned     ref_m;
        longint unsigned     alt_m;
        longint unsigned     sum;
        longint unsigned     bin;
        int unsigned         slot;
        r        = '0;
        cnt_mask = (64'd1 << COUNT_WIDTH) - 1;
        ref_m    = s.ref_reads & cnt_mask;
        alt_m    = s.alt_reads & cnt_mask;
        if (s.cmd == CMD_ACCUM)
        begin
            // Accumulates to a lane beyond the last one leave every field at zero.
            if (s.lane < LANES)
            begin
                sum = ref_m + alt_m;
                // A zero sum is never counted, even with a threshold of zero.
                if (sum != 0 && sum >= cfg_min_reads)
                begin
                    bin = (longint'(pct_bins()) * ref_m) / sum;
                    if (bin > MAX_BINS - 1)
                    begin
                        bin = MAX_BINS - 1;
                    end
                    slot = s.lane * MAX_BINS + bin;
                    if (bin_tally[slot] != 32'hFFFF_FFFF)
                    begin
                        bin_tally[slot] = bin_tally[slot] + 32'd1;
                    end
                    if (lane_tally[s.lane] != 32'hFFFF_FFFF)
                    begin
                        lane_tally[s.lane] = lane_tally[s.lane] + 32'd1;
                    end
                    r.accepted  = 1'b1;
                    r.bin_out   = 7'(bin);
                    r.bin_value = bin_tally[slot];
                end
                r.lane_total = lane_tally[s.lane];
            end
        end
        else
        begin
            r.bin_out = s.bin_sel;
            if (s.lane >= LANES)
            begin
                r.index_error = 1'b1;
            end
            else
            begin
                r.lane_total = lane_tally[s.lane];
                if (s.bin_sel < bins_used())
                begin
                    r.bin_value = bin_tally[s.lane * MAX_BINS + s.bin_sel];
                end
                else
                begin
                    r.index_error = 1'b1;
                end
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic sample_t make_beat(input cmd_t c, input int unsigned ln,
                                          input int unsigned r, input int unsigned a,
                                          input int unsigned b);
        sample_t s;
        s.cmd       = c;
        s.lane      = 4'(ln);
        s.ref_reads = 16'(r);
        s.alt_reads = 16'(a);
        s.bin_sel   = 7'(b);
        return s;
    endfunction

    // Appends one beat to the end of the stimulus list.
    function automatic void queue_beat(input sample_t s);
        pending_samples.insert(pending_samples.size(), s);
    endfunction

    // Mostly sensible beats: lanes in range, reads of bins in use, and read
    // counts chosen to land near the threshold, at the extremes, small or
    // anywhere. The rest address absent lanes or bins.
    function automatic sample_t random_sample();
        sample_t     s;
        int unsigned target;
        int unsigned lo;
        int unsigned hi;
        s.cmd  = ($urandom_range(0, 9) < 7) ? CMD_ACCUM : CMD_READ;
        s.lane = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(LANES, 15))
                                             : 4'($urandom_range(0, LANES - 1));
        s.bin_sel = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                                : 7'($urandom_range(0, bins_used() - 1));
        case ($urandom_range(0, 3))
            0:
            begin
                s.ref_reads = 16'($urandom_range(0, 40));
                s.alt_reads = 16'($urandom_range(0, 40));
            end
            1:
            begin
                s.ref_reads = 16'($urandom);
                s.alt_reads = 16'($urandom);
            end
            2:
            begin
                s.ref_reads = ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)
                              ^ 16'($urandom_range(0, 1));
                s.alt_reads = ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)
                              ^ 16'($urandom_range(0, 1));
            end
            default:
            begin
                // Split a total within two of the threshold between the two counts.
                target = cfg_min_reads + $urandom_range(0, 4);
                target = (target >= 2) ? target - 2 : 0;
                if (target > 131070)
                begin
                    target = 131070;
                end
                lo = (target > 65535) ? target - 65535 : 0;
                hi = (target > 65535) ? 65535 : target;
                s.ref_reads = 16'($urandom_range(lo, hi));
                s.alt_reads = 16'(target - s.ref_reads);
            end
        endcase
        return s;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        if (mismatch_count < PRINT_CAP)
        begin
            $display("[%0t] result %0d: %s is %0d, predicted %0d",
                     $time, result_number, what, got, want);
        end
        mismatch_count++;
    endtask

    // One register access: a setup cycle, then the access cycle, which ends
    // at the edge where pready is seen high.
    task automatic cfg_access(input reg_idx_t idx, input bit is_write,
                              input logic [31:0] data, output logic [31:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= CFG_ADDR_W'(4 * int'(idx));
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Waits until every beat has been offered, accepted and answered. The
    // check is repeated after the quiet stretch, since a beat that the driver
    // puts on the wires at the very edge of the first check is not yet seen.
    task automatic wait_for_drain();
        do
        begin
            while (pending_samples.size() != 0 || item_valid
                   || expected_results.size() != 0)
            begin
                @(posedge clk);
            end
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
        while (pending_samples.size() != 0 || item_valid || expected_results.size() != 0);
    endtask

    // Waits for the core to drain, then writes both registers with random
    // junk above the register width and reads them back.
    task automatic settle_and_configure(input logic [15:0] min_reads,
                                        input logic [6:0] bin_width);
        logic [31:0] rdata;
        wait_for_drain();
        cfg_access(REG_MIN_READ, 1'b1, {16'($urandom), min_reads}, rdata);
        cfg_access(REG_BIN_SIZE, 1'b1, {25'($urandom), bin_width}, rdata);
        cfg_min_reads = min_reads;
        cfg_bin_size  = bin_width;
        cfg_access(REG_MIN_READ, 1'b0, 32'd0, rdata);
        if (rdata != {16'd0, min_reads})
        begin
            report_mismatch("min_read_count readback", rdata, min_reads);
        end
        cfg_access(REG_BIN_SIZE, 1'b0, 32'd0, rdata);
        if (rdata != {25'd0, bin_width})
        begin
            report_mismatch("bin_size readback", rdata, bin_width);
        end
    endtask

    task automatic run_phase(input logic [15:0] min_reads, input logic [6:0] bin_width,
                             input bit long_hold, input bit with_idling);
        settle_and_configure(min_reads, bin_width);
        idling_on = with_idling;
        if (long_hold)
        begin
            holds_asked++;
        end
        repeat (PHASE_BEATS) queue_beat(random_sample());
    endtask

    // ------------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        for (int i = 0; i < MEM_DEPTH; i++)
        begin
            bin_tally[i] = 32'd0;
        end
        for (int i = 0; i < LANES; i++)
        begin
            lane_tally[i] = 32'd0;
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed beats with a threshold of three and ten-percent bins, so
        // that eleven bins are in use. Registers are written while the core
        // is still clearing its store, which it allows.
        settle_and_configure(16'd3, 7'd10);
        queue_beat(make_beat(CMD_ACCUM, 0, 0, 0, 0));          // zero sum
        queue_beat(make_beat(CMD_ACCUM, 0, 1, 1, 0));          // below threshold
        queue_beat(make_beat(CMD_ACCUM, 0, 2, 1, 0));          // at threshold
        queue_beat(make_beat(CMD_ACCUM, 0, 65535, 0, 0));      // top bin
        queue_beat(make_beat(CMD_ACCUM, 0, 0, 65535, 0));      // bottom bin
        queue_beat(make_beat(CMD_ACCUM, 8, 65535, 65535, 0));  // last lane
        queue_beat(make_beat(CMD_ACCUM, 15, 100, 100, 127));   // absent lanes
        queue_beat(make_beat(CMD_ACCUM, 9, 65535, 1, 0));
        queue_beat(make_beat(CMD_ACCUM, 3, 16'hAAAA, 16'h5555, 0));
        queue_beat(make_beat(CMD_ACCUM, 4, 16'h5555, 16'hAAAA, 0));
        queue_beat(make_beat(CMD_ACCUM, 0, 65535, 0, 0));
        queue_beat(make_beat(CMD_READ, 0, 0, 0, 10));          // last bin in use
        queue_beat(make_beat(CMD_READ, 0, 0, 0, 11));          // first bin beyond
        queue_beat(make_beat(CMD_READ, 0, 65535, 65535, 127));
        queue_beat(make_beat(CMD_READ, 0, 0, 0, 0));
        queue_beat(make_beat(CMD_READ, 0, 0, 0, 6));
        queue_beat(make_beat(CMD_READ, 8, 0, 0, 5));
        queue_beat(make_beat(CMD_READ, 3, 0, 0, 3));
        queue_beat(make_beat(CMD_READ, 15, 0, 0, 0));         // absent lanes
        queue_beat(make_beat(CMD_READ, 9, 0, 0, 127));

        // Random settings: one-percent bins under a long receiver hold-off,
        // bin size zero with no threshold, the largest threshold, a bin size
        // above one hundred, narrow bins, and finally a run with no idling.
        run_phase(16'd1,     7'd1,   1'b1, 1'b1);
        run_phase(16'd0,     7'd0,   1'b0, 1'b1);
        run_phase(16'd65535, 7'd100, 1'b0, 1'b1);
        run_phase(16'd20,    7'd127, 1'b0, 1'b1);
        run_phase(16'd5,     7'd3,   1'b0, 1'b1);
        run_phase(16'd2,     7'd10,  1'b0, 1'b0);

        wait_for_drain();
        if (mismatch_count == 0)
        begin
            $display("allele_ratio_histogram_core verification clean");
        end
        else
        begin
            $display("allele_ratio_histogram_core verification failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Item driver. A beat is predicted at the edge that accepts it; the next
    // beat, or an idle gap, is put on the wires only once the slot is free,
    // so a stalled beat never changes.
    // ------------------------------------------------------------------------
    sample_t     beat_on_wire;
    int unsigned send_gap = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                expected_results.insert(expected_results.size(),
                                        tally_sample(beat_on_wire));
            end
            if (!item_valid || !item_stall)
            begin
                if (send_gap != 0)
                begin
                    send_gap   = send_gap - 1;
                    item_valid <= 1'b0;
                end
                else if (pending_samples.size() != 0)
                begin
                    beat_on_wire = pending_samples.pop_front();
                    item_valid <= 1'b1;
                    command    <= beat_on_wire.cmd;
                    lane       <= beat_on_wire.lane;
                    ref_count  <= beat_on_wire.ref_reads;
                    alt_count  <= beat_on_wire.alt_reads;
                    read_bin   <= beat_on_wire.bin_sel;
                    // Now and then a burst of idle cycles follows this beat.
                    if (idling_on && $urandom_range(0, 5) == 0)
                    begin
                        send_gap = $urandom_range(1, 16);
                    end
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor. Checks each accepted result beat against the oldest
    // prediction and decides the stall for the next cycle: a requested long
    // hold-off first, otherwise random bursts while idling is on.
    // ------------------------------------------------------------------------
    int unsigned stall_left = 0;

    always @(posedge clk)
    begin : result_monitor
        res_t want;
        logic hold_now;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result beat, bin_out", bin_out, 0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (accepted !== want.accepted)
                    begin
                        report_mismatch("accepted", accepted, want.accepted);
                    end
                    if (bin_out !== want.bin_out)
                    begin
                        report_mismatch("bin_out", bin_out, want.bin_out);
                    end
                    if (bin_value !== want.bin_value)
                    begin
                        report_mismatch("bin_value", bin_value, want.bin_value);
                    end
                    if (lane_total !== want.lane_total)
                    begin
                        report_mismatch("lane_total", lane_total, want.lane_total);
                    end
                    if (index_error !== want.index_error)
                    begin
                        report_mismatch("index_error", index_error, want.index_error);
                    end
                end
                result_number++;
            end

            if (stall_left != 0)
            begin
                stall_left = stall_left - 1;
                hold_now   = 1'b1;
            end
            else if (holds_served != holds_asked)
            begin
                holds_served++;
                stall_left = HOLD_OFF_CYCLES - 1;
                hold_now   = 1'b1;
            end
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 15);
                hold_now   = 1'b1;
            end
            else
            begin
                hold_now = 1'b0;
            end
            result_stall <= hold_now;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run if no beat moves on either channel for too long.
    // ------------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("allele_ratio_histogram_core verification failed");
            $finish;
        end
    end

endmodule

// File: files.f
hw/rtl/arh_pkg.sv
hw/rtl/arh_ram.sv
hw/rtl/arh_front.sv
hw/rtl/arh_queue.sv
hw/rtl/arh_back.sv
hw/rtl/allele_ratio_histogram_core.sv
tb/sv/tb_allele_ratio_histogram_core.sv
